// ===== rtl/terminal_key_sequence_decoder_defines.svh =====
// Assertion macros used by the key decoder checker.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define TKSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also runs through reset.
`define TKSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tksd_pkg.sv =====
// Types, codes and lookup functions for the terminal key sequence decoder.
`default_nettype none
package tksd_pkg;

   localparam int SEQ_MAX_CHARS_DEF = 4;
   localparam int MATCH_CHARS       = 4;
   localparam int RSP_FIFO_DEPTH    = 4;
   localparam int CP_W              = 21;
   localparam int KEY_W             = 7;
   localparam int LOOKUP_LEN_W      = 4;

   localparam logic [1:0] EV_CHAR = 2'd0;
   localparam logic [1:0] EV_KEY  = 2'd1;
   localparam logic [1:0] EV_END  = 2'd2;

   localparam logic [KEY_W-1:0] KEY_UP     = 7'd1;
   localparam logic [KEY_W-1:0] KEY_DOWN   = 7'd2;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 7'd3;
   localparam logic [KEY_W-1:0] KEY_RIGHT  = 7'd4;
   localparam logic [KEY_W-1:0] KEY_HOME   = 7'd5;
   localparam logic [KEY_W-1:0] KEY_END    = 7'd6;
   localparam logic [KEY_W-1:0] KEY_INSERT = 7'd7;
   localparam logic [KEY_W-1:0] KEY_BACK   = 7'd8;
   localparam logic [KEY_W-1:0] KEY_DELETE = 7'd9;
   localparam logic [KEY_W-1:0] KEY_PGUP   = 7'd10;
   localparam logic [KEY_W-1:0] KEY_PGDN   = 7'd11;
   localparam logic [KEY_W-1:0] KEY_ESC    = 7'd27;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 7'd32;
   localparam logic [KEY_W-1:0] KEY_F1     = 7'd101;
   localparam logic [KEY_W-1:0] KEY_F2     = 7'd102;
   localparam logic [KEY_W-1:0] KEY_F3     = 7'd103;
   localparam logic [KEY_W-1:0] KEY_F4     = 7'd104;
   localparam logic [KEY_W-1:0] KEY_F5     = 7'd105;
   localparam logic [KEY_W-1:0] KEY_F6     = 7'd106;
   localparam logic [KEY_W-1:0] KEY_F7     = 7'd107;
   localparam logic [KEY_W-1:0] KEY_F8     = 7'd108;
   localparam logic [KEY_W-1:0] KEY_F9     = 7'd109;
   localparam logic [KEY_W-1:0] KEY_F10    = 7'd110;
   localparam logic [KEY_W-1:0] KEY_F11    = 7'd111;
   localparam logic [KEY_W-1:0] KEY_F12    = 7'd112;
   localparam logic [KEY_W-1:0] KEY_F13    = 7'd113;
   localparam logic [KEY_W-1:0] KEY_F14    = 7'd114;
   localparam logic [KEY_W-1:0] KEY_F15    = 7'd115;
   localparam logic [KEY_W-1:0] KEY_F16    = 7'd116;
   localparam logic [KEY_W-1:0] KEY_F17    = 7'd117;
   localparam logic [KEY_W-1:0] KEY_F18    = 7'd118;
   localparam logic [KEY_W-1:0] KEY_F19    = 7'd119;
   localparam logic [KEY_W-1:0] KEY_F20    = 7'd120;

   localparam logic [CP_W-1:0] CP_NUL   = 21'h00;
   localparam logic [CP_W-1:0] CP_TAB   = 21'h09;
   localparam logic [CP_W-1:0] CP_LF    = 21'h0A;
   localparam logic [CP_W-1:0] CP_CR    = 21'h0D;
   localparam logic [CP_W-1:0] CP_ESC   = 21'h1B;
   localparam logic [CP_W-1:0] CP_SPACE = 21'h20;
   localparam logic [CP_W-1:0] CP_DEL   = 21'h7F;
   localparam logic [CP_W-1:0] CP_SS3   = 21'h4F;
   localparam logic [CP_W-1:0] CP_CSI   = 21'h5B;
   localparam logic [CP_W-1:0] CP_TILDE = 21'h7E;
   localparam logic [CP_W-1:0] CP_UC_A  = 21'h41;
   localparam logic [CP_W-1:0] CP_UC_Z  = 21'h5A;
   localparam logic [1:0]      CTRL_KEY_PREFIX = 2'b10;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       more_waiting;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic [CP_W-1:0]  char_code;
      logic [KEY_W-1:0] key_code;
      logic             control_flag;
      logic             last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_pair_type;

   typedef struct packed {
      logic       hit;
      logic [KEY_W-1:0] key;
      logic       ctrl;
   } seq_hit_type;

   typedef struct packed {
      logic    emit;
      logic    to_escape;
      rsp_type rsp;
   } idle_out_type;

   function automatic rsp_type key_rsp(input logic [KEY_W-1:0] key, input logic ctrl);
      rsp_type r;
      r              = '0;
      r.event_kind   = EV_KEY;
      r.key_code     = key;
      r.control_flag = ctrl;
      return r;
   endfunction

   function automatic rsp_type char_rsp(input logic [CP_W-1:0] cp);
      rsp_type r;
      r            = '0;
      r.event_kind = EV_CHAR;
      r.char_code  = cp;
      return r;
   endfunction

   function automatic rsp_type end_rsp();
      rsp_type r;
      r            = '0;
      r.event_kind = EV_END;
      return r;
   endfunction

   function automatic seq_hit_type hit(input logic [KEY_W-1:0] key, input logic ctrl);
      seq_hit_type r;
      r.hit  = 1'b1;
      r.key  = key;
      r.ctrl = ctrl;
      return r;
   endfunction

   function automatic idle_out_type handle_idle(input logic [CP_W-1:0] cp, input logic more);
      idle_out_type r;
      r = '0;
      if (cp == CP_NUL) begin
         r.emit = 1'b1;
         r.rsp  = key_rsp(KEY_SPACE, 1'b1);
      end else if (cp == CP_TAB || cp == CP_LF || cp == CP_CR) begin
         r.emit = 1'b1;
         r.rsp  = char_rsp(cp);
      end else if (cp < CP_ESC) begin
         r.emit = 1'b1;
         r.rsp  = key_rsp({CTRL_KEY_PREFIX, cp[4:0]}, 1'b1);
      end else if (cp == CP_ESC) begin
         if (more) begin
            r.to_escape = 1'b1;
         end else begin
            r.emit = 1'b1;
            r.rsp  = key_rsp(KEY_ESC, 1'b0);
         end
      end else if (cp < CP_SPACE) begin
         r.emit = 1'b0;
      end else if (cp == CP_DEL) begin
         r.emit = 1'b1;
         r.rsp  = key_rsp(KEY_BACK, 1'b0);
      end else begin
         r.emit = 1'b1;
         r.rsp  = char_rsp(cp);
      end
      return r;
   endfunction

   // Known escape sequences; only the first len characters are looked at.
   function automatic seq_hit_type seq_lookup(input logic bracket,
                                              input logic [LOOKUP_LEN_W-1:0] len,
                                              input logic [MATCH_CHARS-1:0][6:0] c);
      seq_hit_type r;
      r = '0;
      case (len)
         4'd1: begin
            if (!bracket) begin
               case (c[0])
                  7'("A"): r = hit(KEY_UP, 1'b0);
                  7'("B"): r = hit(KEY_DOWN, 1'b0);
                  7'("C"): r = hit(KEY_RIGHT, 1'b0);
                  7'("D"): r = hit(KEY_LEFT, 1'b0);
                  7'("H"): r = hit(KEY_HOME, 1'b0);
                  7'("F"): r = hit(KEY_END, 1'b0);
                  7'("P"): r = hit(KEY_F1, 1'b0);
                  7'("Q"): r = hit(KEY_F2, 1'b0);
                  7'("R"): r = hit(KEY_F3, 1'b0);
                  7'("S"): r = hit(KEY_F4, 1'b0);
                  default: r = '0;
               endcase
            end else begin
               case (c[0])
                  7'("1"): r = hit(KEY_HOME, 1'b0);
                  7'("2"): r = hit(KEY_INSERT, 1'b0);
                  7'("3"): r = hit(KEY_DELETE, 1'b0);
                  7'("4"): r = hit(KEY_END, 1'b0);
                  7'("5"): r = hit(KEY_PGUP, 1'b0);
                  7'("6"): r = hit(KEY_PGDN, 1'b0);
                  7'("7"): r = hit(KEY_HOME, 1'b0);
                  7'("8"): r = hit(KEY_END, 1'b0);
                  7'("A"): r = hit(KEY_UP, 1'b0);
                  7'("B"): r = hit(KEY_DOWN, 1'b0);
                  7'("C"): r = hit(KEY_RIGHT, 1'b0);
                  7'("D"): r = hit(KEY_LEFT, 1'b0);
                  7'("F"): r = hit(KEY_END, 1'b0);
                  7'("H"): r = hit(KEY_HOME, 1'b0);
                  default: r = '0;
               endcase
            end
         end
         4'd2: begin
            if (bracket && c[0] == 7'("1")) begin
               case (c[1])
                  7'("1"): r = hit(KEY_F1, 1'b0);
                  7'("2"): r = hit(KEY_F2, 1'b0);
                  7'("3"): r = hit(KEY_F3, 1'b0);
                  7'("4"): r = hit(KEY_F4, 1'b0);
                  7'("5"): r = hit(KEY_F5, 1'b0);
                  7'("7"): r = hit(KEY_F6, 1'b0);
                  7'("8"): r = hit(KEY_F7, 1'b0);
                  7'("9"): r = hit(KEY_F8, 1'b0);
                  7'("P"): r = hit(KEY_F1, 1'b0);
                  7'("Q"): r = hit(KEY_F2, 1'b0);
                  7'("R"): r = hit(KEY_F3, 1'b0);
                  7'("S"): r = hit(KEY_F4, 1'b0);
                  default: r = '0;
               endcase
            end else if (bracket && c[0] == 7'("2")) begin
               case (c[1])
                  7'("0"): r = hit(KEY_F9, 1'b0);
                  7'("1"): r = hit(KEY_F10, 1'b0);
                  7'("3"): r = hit(KEY_F11, 1'b0);
                  7'("4"): r = hit(KEY_F12, 1'b0);
                  7'("5"): r = hit(KEY_F13, 1'b0);
                  7'("6"): r = hit(KEY_F14, 1'b0);
                  7'("8"): r = hit(KEY_F15, 1'b0);
                  7'("9"): r = hit(KEY_F16, 1'b0);
                  default: r = '0;
               endcase
            end else if (bracket && c[0] == 7'("3")) begin
               case (c[1])
                  7'("1"): r = hit(KEY_F17, 1'b0);
                  7'("2"): r = hit(KEY_F18, 1'b0);
                  7'("3"): r = hit(KEY_F19, 1'b0);
                  7'("4"): r = hit(KEY_F20, 1'b0);
                  default: r = '0;
               endcase
            end
         end
         4'd4: begin
            if (bracket && c[0] == 7'("1") && c[1] == 7'(";") && c[2] == 7'("5")) begin
               case (c[3])
                  7'("A"): r = hit(KEY_UP, 1'b1);
                  7'("B"): r = hit(KEY_DOWN, 1'b1);
                  7'("C"): r = hit(KEY_RIGHT, 1'b1);
                  7'("D"): r = hit(KEY_LEFT, 1'b1);
                  default: r = '0;
               endcase
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/terminal_key_sequence_decoder.sv =====
// Top level of the terminal key sequence decoder.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_payload : tksd_pkg::req_type
//   rsp      out  rsp_valid/rsp_stall   rsp_payload : tksd_pkg::rsp_type
//
// One request per cycle while req_stall is low; each gives 0, 1 or 2 responses, decoded in the
// cycle taken, queued in a 4-entry response queue; one out per cycle while rsp_stall is low.
// With the queue empty, a request's first response appears the cycle after it is taken.
// req_stall rises when the queue holds more than two responses.
// Synchronous reset clears decoder state and the queue; collected sequence chars are not reset.
`default_nettype none
module terminal_key_sequence_decoder #(
   parameter int SEQ_MAX_CHARS = tksd_pkg::SEQ_MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tksd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tksd_pkg::rsp_type rsp_payload
);
   import tksd_pkg::*;

   logic          accept;
   logic          can_accept;
   rsp_pair_type  pair;

   assign req_stall = !can_accept;
   assign accept    = req_valid && can_accept;

   tksd_decode #(
      .SEQ_MAX_CHARS(SEQ_MAX_CHARS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .pair   (pair)
   );

   tksd_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .pair        (pair),
      .can_accept  (can_accept),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== rtl/tksd_decode.sv =====
// Decoder state and per-byte decode: UTF-8 assembly, escape handling, sequence lookup.
`default_nettype none
module tksd_decode #(
   parameter int SEQ_MAX_CHARS = tksd_pkg::SEQ_MAX_CHARS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tksd_pkg::req_type      req,
   output tksd_pkg::rsp_pair_type pair
);
   import tksd_pkg::*;

   localparam int LEN_W = $clog2(SEQ_MAX_CHARS + 1);
   localparam int IDX_W = $clog2(SEQ_MAX_CHARS);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_ESC  = 3'b010,
      MODE_SEQ  = 3'b100
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [1:0]        pending_ff, pending_in;
   logic [CP_W-1:0]   accum_ff, accum_in;
   logic              bracket_ff, bracket_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [6:0]        chars_ff [SEQ_MAX_CHARS];
   logic [6:0]        chars_in [SEQ_MAX_CHARS];

   logic                          have_cp;
   logic [CP_W-1:0]               cp;
   logic [CP_W-1:0]               acc_shift;
   logic [1:0]                    pend_dec;
   logic                          is_letter;
   logic                          is_tilde;
   logic                          do_store;
   logic                          seq_end;
   logic [MATCH_CHARS-1:0][6:0]   look_cur;
   logic [MATCH_CHARS-1:0][6:0]   look_new;
   seq_hit_type                   hit_cur;
   seq_hit_type                   hit_new;
   idle_out_type                  idle_res;
   logic                          a_valid, b_valid;
   rsp_type                       a_rsp, b_rsp;
   logic                          first_valid;
   rsp_type                       first_rsp;

   always_comb begin
      for (int i = 0; i < MATCH_CHARS; i++) begin
         look_cur[i] = chars_ff[i];
         look_new[i] = chars_in[i];
      end
   end

   assign hit_cur = seq_lookup(bracket_ff, LOOKUP_LEN_W'(len_ff), look_cur);
   assign hit_new = seq_lookup(bracket_ff, LOOKUP_LEN_W'(len_in), look_new);

   assign acc_shift = {accum_ff[CP_W-7:0], req.raw_byte[5:0]};
   assign pend_dec  = pending_ff - 2'd1;

   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      accum_in   = accum_ff;
      bracket_in = bracket_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      for (int i = 0; i < SEQ_MAX_CHARS; i++) begin
         chars_in[i] = chars_ff[i];
      end
      have_cp   = 1'b0;
      cp        = {{(CP_W-8){1'b0}}, req.raw_byte};
      is_letter = 1'b0;
      is_tilde  = 1'b0;
      do_store  = 1'b0;
      seq_end   = 1'b0;
      idle_res  = '0;
      a_valid   = 1'b0;
      a_rsp     = '0;
      b_valid   = 1'b0;
      b_rsp     = '0;

      if (req.end_of_stream) begin
         case (mode_ff)
            MODE_ESC: begin
               a_valid = 1'b1;
               a_rsp   = key_rsp(KEY_ESC, 1'b0);
            end
            MODE_SEQ: begin
               a_valid = hit_cur.hit && !ovf_ff;
               a_rsp   = key_rsp(hit_cur.key, hit_cur.ctrl);
            end
            default: a_valid = 1'b0;
         endcase
         mode_in = MODE_IDLE;
         b_valid = 1'b1;
         b_rsp   = end_rsp();
      end else begin
         if (pending_ff != 2'd0) begin
            accum_in   = acc_shift;
            pending_in = pend_dec;
            if (pend_dec == 2'd0) begin
               have_cp = 1'b1;
               cp      = acc_shift;
            end
         end else if (req.raw_byte[7]) begin
            if (req.raw_byte[5]) begin
               if (req.raw_byte[4]) begin
                  accum_in   = {{(CP_W-3){1'b0}}, req.raw_byte[2:0]};
                  pending_in = 2'd3;
               end else begin
                  accum_in   = {{(CP_W-4){1'b0}}, req.raw_byte[3:0]};
                  pending_in = 2'd2;
               end
            end else begin
               accum_in   = {{(CP_W-5){1'b0}}, req.raw_byte[4:0]};
               pending_in = 2'd1;
            end
         end else begin
            have_cp = 1'b1;
         end

         idle_res = handle_idle(cp, req.more_waiting);

         if (have_cp) begin
            case (mode_ff)
               MODE_ESC: begin
                  if (cp == CP_SS3 || cp == CP_CSI) begin
                     bracket_in = (cp == CP_CSI);
                     len_in     = '0;
                     ovf_in     = 1'b0;
                     mode_in    = MODE_SEQ;
                  end else begin
                     a_valid = 1'b1;
                     a_rsp   = key_rsp(KEY_ESC, 1'b0);
                     b_valid = idle_res.emit;
                     b_rsp   = idle_res.rsp;
                     mode_in = idle_res.to_escape ? MODE_ESC : MODE_IDLE;
                  end
               end
               MODE_SEQ: begin
                  is_letter = (cp >= CP_UC_A) && (cp <= CP_UC_Z);
                  is_tilde  = (cp == CP_TILDE);
                  do_store  = is_letter || (!is_tilde && cp > CP_SPACE);
                  if (do_store) begin
                     if (cp > CP_DEL || len_ff >= LEN_W'(SEQ_MAX_CHARS)) begin
                        ovf_in = 1'b1;
                     end else begin
                        chars_in[len_ff[IDX_W-1:0]] = cp[6:0];
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  if (is_letter || is_tilde) begin
                     mode_in = MODE_IDLE;
                     seq_end = 1'b1;
                  end
               end
               default: begin
                  b_valid = idle_res.emit;
                  b_rsp   = idle_res.rsp;
                  mode_in = idle_res.to_escape ? MODE_ESC : MODE_IDLE;
               end
            endcase
         end
      end
   end

   // sequence end looks up the updated chars, kept apart from the next-state block
   always_comb begin
      first_valid = a_valid || (seq_end && hit_new.hit && !ovf_in);
      first_rsp   = seq_end ? key_rsp(hit_new.key, hit_new.ctrl) : a_rsp;
      pair.count  = {1'b0, first_valid} + {1'b0, b_valid};
      pair.first  = first_valid ? first_rsp : b_rsp;
      pair.second = b_rsp;
      pair.first.last_of_run  = !(first_valid && b_valid);
      pair.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pending_ff <= '0;
         accum_ff   <= '0;
         bracket_ff <= 1'b0;
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         bracket_ff <= bracket_in;
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < SEQ_MAX_CHARS; i++) begin
            chars_ff[i] <= chars_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tksd_rsp_fifo.sv =====
// Response queue: takes up to two per request, one out per cycle unless stalled.
`default_nettype none
module tksd_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tksd_pkg::rsp_pair_type pair,
   output logic                   can_accept,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tksd_pkg::rsp_type      rsp_payload
);
   import tksd_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_type           mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  push_n;
   logic              pop;
   logic [PTR_W-1:0]  wr_next;

   assign can_accept  = count_ff <= CNT_W'(RSP_FIFO_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = mem_ff[rd_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign push_n      = push ? CNT_W'(pair.count) : '0;
   assign wr_next     = wr_ff + PTR_W'(1);
   assign wr_in       = wr_ff + PTR_W'(push_n);
   assign rd_in       = rd_ff + PTR_W'(pop);
   assign count_in    = count_ff + push_n - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pair.count != 2'd0) begin
         mem_ff[wr_ff] <= pair.first;
      end
      if (push && pair.count == 2'd2) begin
         mem_ff[wr_next] <= pair.second;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tksd_checker.sv =====
// Port-level checker for the terminal key sequence decoder, with its bind.
`default_nettype none
`include "terminal_key_sequence_decoder_defines.svh"
module tksd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tksd_pkg::rsp_type rsp_payload
);
   import tksd_pkg::*;

   `TKSD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response after reset")
   `TKSD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `TKSD_ASSERT(a_end_is_last, clock, reset, rsp_valid && rsp_payload.event_kind == EV_END |-> rsp_payload.last_of_run, "end event not last")
   `TKSD_ASSERT(a_key_no_char, clock, reset, rsp_valid && rsp_payload.event_kind != EV_CHAR |-> rsp_payload.char_code == '0, "char code on non-char event")
   `TKSD_ASSERT(a_char_no_key, clock, reset, rsp_valid && rsp_payload.event_kind == EV_CHAR |-> rsp_payload.key_code == '0 && !rsp_payload.control_flag, "key fields on char event")

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);
`default_nettype wire
